// ----- design/mma_pkg.sv -----
// shared types and constants for the matrix multiply-add block
// no dependencies
package mma_pkg;

  localparam int SIDE      = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DATA_W    = 32;
  localparam int DIM_DFLT  = 8;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    KIND_A       = 2'd0,
    KIND_B       = 2'd1,
    KIND_C       = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  // bookkeeping that travels with one product through the pipeline
  typedef struct packed {
    logic first;   // first k term of an element
    logic last_k;  // final k term, element done
    idx_t row;
    idx_t col;
    logic last;    // final element of the matrix
  } tag_t;

endpackage

// ----- design/matrix_multiply_add.sv -----
// matrix_multiply_add: D = A*B + C on DIM x DIM signed 32-bit matrices, wrapping
// load items are accepted back to back while idle
// a compute item issues one A/B memory read pair per k term, then drains the
// pipeline; issue pauses while a result waits unaccepted at the output
// the single multiplier and the one read port per memory bound the result rate
// reset (synchronous, rst_n low) clears control only; matrix memories are not cleared
module matrix_multiply_add #(
  parameter int DIM = mma_pkg::DIM_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  mma_pkg::idx_t       in_row,
  input  mma_pkg::idx_t       in_col,
  input  mma_pkg::data_t      in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output mma_pkg::idx_t       out_row,
  output mma_pkg::idx_t       out_col,
  output mma_pkg::data_t      out_result,
  output logic                out_last
);
  import mma_pkg::*;

  localparam idx_t       LAST_IDX = idx_t'(DIM - 1);
  localparam logic [IDX_W:0] DIM_W = (IDX_W + 1)'(DIM);

  // matrix storage, one synchronous memory per operand
  data_t mem_a [SIDE*SIDE];
  data_t mem_b [SIDE*SIDE];
  data_t mem_c [SIDE*SIDE];

  state_t state_r, state_nxt;
  idx_t   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic   in_fire, load_ok, issue, adv, issue_done;
  addr_t  waddr;

  // stage 1: registered memory read data
  logic   v1_r;
  tag_t   tag1_r;
  data_t  a_rd_r, b_rd_r, c_rd_r;

  // stage 2: registered product
  logic   v2_r;
  tag_t   tag2_r;
  data_t  prod_r, c2_r;

  // accumulator and output register
  data_t  acc_r, acc_nxt;
  logic   out_valid_r;
  idx_t   out_row_r, out_col_r;
  data_t  out_result_r;
  logic   out_last_r;

  // whole pipeline freezes while a finished item sits unaccepted in the output
  assign adv      = !(out_valid_r && !out_ready);
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign waddr    = {in_row, in_col};
  // loads outside the DIM x DIM square are dropped
  assign load_ok  = ({1'b0, in_row} < DIM_W) && ({1'b0, in_col} < DIM_W);

  // ---------------------------------------------------------------- fsm
  assign issue_done = (i_r == LAST_IDX) && (j_r == LAST_IDX) && (k_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (kind_t'(in_kind) == KIND_COMPUTE)) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (adv && issue_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    issue = (state_r == ST_RUN) && adv;
  end

  // loop counters, k innermost
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (in_fire) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else if (issue) begin
      if (k_r == LAST_IDX) begin
        k_nxt = '0;
        if (j_r == LAST_IDX) begin
          j_nxt = '0;
          i_nxt = i_r + idx_t'(1);
        end else begin
          j_nxt = j_r + idx_t'(1);
        end
      end else begin
        k_nxt = k_r + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (in_fire && load_ok && (kind_t'(in_kind) == KIND_A)) mem_a[waddr] <= in_value;
    if (issue) a_rd_r <= mem_a[{i_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (in_fire && load_ok && (kind_t'(in_kind) == KIND_B)) mem_b[waddr] <= in_value;
    if (issue) b_rd_r <= mem_b[{k_r, j_r}];
  end

  // addend read every issue cycle; same address for all k of one element
  always_ff @(posedge clk) begin
    if (in_fire && load_ok && (kind_t'(in_kind) == KIND_C)) mem_c[waddr] <= in_value;
    if (issue) c_rd_r <= mem_c[{i_r, j_r}];
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      tag1_r.first  <= (k_r == '0);
      tag1_r.last_k <= (k_r == LAST_IDX);
      tag1_r.row    <= i_r;
      tag1_r.col    <= j_r;
      tag1_r.last   <= (i_r == LAST_IDX) && (j_r == LAST_IDX);
    end
    if (adv && v1_r) begin
      tag2_r <= tag1_r;
      // low 32 bits of the product are the same for signed and unsigned
      prod_r <= data_t'(a_rd_r * b_rd_r);
      c2_r   <= c_rd_r;
    end
  end

  // accumulation starts from the addend element
  always_comb begin
    acc_nxt = (tag2_r.first ? c2_r : acc_r) + prod_r;
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) acc_r <= acc_nxt;
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r && tag2_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r && tag2_r.last_k) begin
      out_row_r    <= tag2_r.row;
      out_col_r    <= tag2_r.col;
      out_result_r <= acc_nxt;
      out_last_r   <= tag2_r.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_result = out_result_r;
  assign out_last   = out_last_r;

endmodule
